FILE: rtl/core/switch_bank_debounce_change_reporter_macros.svh
// assertion macros for the switch bank debounce change reporter
`ifndef SWITCH_BANK_DEBOUNCE_CHANGE_REPORTER_MACROS_SVH
`define SWITCH_BANK_DEBOUNCE_CHANGE_REPORTER_MACROS_SVH

// checked only outside reset
`define SBDCR_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// checked at every edge, reset included
`define SBDCR_ASSERT(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: rtl/core/sbdcr_pkg.sv
package sbdcr_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int SENSE_W = 32;
  localparam int LOCK_NUM_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 8'd1;

  localparam logic [15:0] DETECT_INTERVAL_RESET = 16'd20;
  localparam logic [15:0] REPORT_INTERVAL_RESET = 16'd50;

  localparam logic [LOCK_NUM_W-1:0] LOCK_NUM_BASE = 6'h01;

  typedef enum logic [1:0] {
    PH_READY,
    PH_FIRST,
    PH_SECOND,
    PH_COMMIT
  } phase_t;

  typedef struct packed {
    logic                  found;
    logic [LOCK_NUM_W-1:0] index;
    logic [LOCK_NUM_W-1:0] count;
  } scan_t;

endpackage

FILE: rtl/core/sbdcr_if.sv
interface sbdcr_in_if;
  logic                           valid;
  logic                           ready;
  logic [sbdcr_pkg::SENSE_W-1:0]  lock_inputs;

  modport source (output valid, output lock_inputs, input ready);
  modport sink (input valid, input lock_inputs, output ready);
endinterface

interface sbdcr_out_if;
  logic                             valid;
  logic                             ready;
  logic [sbdcr_pkg::LOCK_NUM_W-1:0] lock_number;
  logic                             new_level;
  logic [sbdcr_pkg::SENSE_W-1:0]    debounced_state;

  modport source (output valid, output lock_number, output new_level,
                  output debounced_state, input ready);
  modport sink (input valid, input lock_number, input new_level,
                input debounced_state, output ready);
endinterface

interface sbdcr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbdcr_pkg::CFG_IDX_W-1:0]  index;
  logic [sbdcr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/switch_bank_debounce_change_reporter.sv
// switch bank debounce change reporter
// lock_in: one request per timer tick, carrying the parallel lock sense word.
// report_out: zero or one request per tick, giving the one-based lock number,
//   its new debounced level and the whole committed debounced word.
// cfg: register writes (index 0 detect interval, index 1 report interval), always ready
//   outside reset; the user makes them only while no tick is in flight, not enforced.
// flow: a tick is taken into an input register, worked through combinationally, and
//   its report, if any, is registered onto report_out once the report register is free.
// throughput: one tick per cycle while report_out does not stall; all per-tick work
//   (timer decrement, debounce phase, popcount and lowest-bit search over the lock
//   word) sits between the input register and the report register.
// reset (rst, synchronous): intervals return to 20 and 50 ticks, the
//   debouncer goes to its ready phase, timers and lock words clear and any
//   held report is dropped; lock_in and cfg are not ready during reset.
// stall: a report held on report_out keeps its value until taken; the tick
//   in the input register waits behind it and lock_in drops ready, so no
//   tick or report is lost.
module switch_bank_debounce_change_reporter #(
  parameter int NUM_LOCKS = 32
) (
  input  logic          clk,
  input  logic          rst,
  sbdcr_in_if.sink      lock_in,
  sbdcr_out_if.source   report_out,
  sbdcr_cfg_if.sink     cfg
);

  localparam int LW = (NUM_LOCKS < sbdcr_pkg::SENSE_W) ? NUM_LOCKS : sbdcr_pkg::SENSE_W;
  localparam int LIDX_W = $clog2(LW);

  logic                  s1_valid;
  logic [LW-1:0]         s1_sense;
  logic                  advance;

  logic [15:0]           detect_interval;
  logic [15:0]           report_interval;

  sbdcr_pkg::phase_t     phase, phase_next;
  logic [LW-1:0]         first_sample, first_sample_next;
  logic [LW-1:0]         second_sample, second_sample_next;
  logic [LW-1:0]         stable_state, stable_state_next;
  logic [LW-1:0]         reported_bits, reported_bits_next;
  logic [LW-1:0]         target_bits, target_bits_next;
  logic [15:0]           detect_timer, detect_timer_next;
  logic [15:0]           report_timer, report_timer_next;
  logic [sbdcr_pkg::LOCK_NUM_W-1:0] pending_count, pending_count_next;

  logic [15:0]           dt_dec, rt_dec;
  logic                  snapshot;
  logic [LW-1:0]         rep_base;
  logic [LW-1:0]         diff;
  logic [sbdcr_pkg::LOCK_NUM_W-1:0] pend_base;
  logic                  emit;
  sbdcr_pkg::scan_t      scan;
  logic [LIDX_W-1:0]     bit_sel;

  logic                  out_valid;
  logic [sbdcr_pkg::LOCK_NUM_W-1:0] out_lock_number;
  logic                  out_new_level;
  logic [sbdcr_pkg::SENSE_W-1:0]    out_debounced_state;

  assign advance       = s1_valid && (!out_valid || report_out.ready);
  assign lock_in.ready = !rst && (!s1_valid || advance);
  assign cfg.ready     = !rst;

  // snapshot of the debounced word when the reporter runs idle
  assign rt_dec   = (report_timer != 16'd0) ? report_timer - 16'd1 : report_timer;
  assign snapshot = (rt_dec == 16'd0) && (pending_count == '0);
  assign rep_base = snapshot ? target_bits : reported_bits;
  assign target_bits_next = snapshot ? stable_state_next : target_bits;
  assign diff     = rep_base ^ target_bits_next;

  sbdcr_diff_scan #(.W(LW)) u_scan (
    .diff (diff),
    .scan (scan)
  );

  assign bit_sel = scan.index[LIDX_W-1:0];

  always_comb begin
    dt_dec = (detect_timer != 16'd0) ? detect_timer - 16'd1 : detect_timer;
    phase_next = phase;
    first_sample_next = first_sample;
    second_sample_next = second_sample;
    stable_state_next = stable_state;
    detect_timer_next = dt_dec;
    case (phase)
      sbdcr_pkg::PH_READY: begin
        detect_timer_next = detect_interval;
        phase_next = sbdcr_pkg::PH_FIRST;
      end
      sbdcr_pkg::PH_FIRST: begin
        if (dt_dec == 16'd0) begin
          first_sample_next = s1_sense;
          detect_timer_next = detect_interval;
          phase_next = sbdcr_pkg::PH_SECOND;
        end
      end
      sbdcr_pkg::PH_SECOND: begin
        if (dt_dec == 16'd0) begin
          second_sample_next = s1_sense;
          phase_next = sbdcr_pkg::PH_COMMIT;
        end
      end
      default: begin
        if (first_sample == second_sample) begin
          stable_state_next = first_sample;
        end
        phase_next = sbdcr_pkg::PH_READY;
      end
    endcase
  end

  always_comb begin
    pend_base = snapshot ? scan.count : pending_count;
    emit = 1'b0;
    reported_bits_next = rep_base;
    pending_count_next = pend_base;
    report_timer_next = rt_dec;
    if (rt_dec == 16'd0) begin
      if (pend_base != '0) begin
        emit = scan.found;
        if (scan.found) begin
          reported_bits_next = rep_base ^ (LW'(1) << bit_sel);
        end
        pending_count_next = pend_base - sbdcr_pkg::LOCK_NUM_W'(1);
      end
      report_timer_next = report_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (lock_in.valid && lock_in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lock_in.valid && lock_in.ready) begin
      s1_sense <= lock_in.lock_inputs[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_interval <= sbdcr_pkg::DETECT_INTERVAL_RESET;
      report_interval <= sbdcr_pkg::REPORT_INTERVAL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        sbdcr_pkg::REG_DETECT_INTERVAL: detect_interval <= cfg.data;
        sbdcr_pkg::REG_REPORT_INTERVAL: report_interval <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sbdcr_pkg::PH_READY;
      first_sample  <= '0;
      second_sample <= '0;
      stable_state  <= '0;
      reported_bits <= '0;
      target_bits   <= '0;
      detect_timer  <= '0;
      report_timer  <= '0;
      pending_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      first_sample  <= first_sample_next;
      second_sample <= second_sample_next;
      stable_state  <= stable_state_next;
      reported_bits <= reported_bits_next;
      target_bits   <= target_bits_next;
      detect_timer  <= detect_timer_next;
      report_timer  <= report_timer_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (report_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_lock_number     <= scan.index + sbdcr_pkg::LOCK_NUM_BASE;
      out_new_level       <= target_bits_next[bit_sel];
      out_debounced_state <= sbdcr_pkg::SENSE_W'(stable_state_next);
    end
  end

  assign report_out.valid           = out_valid;
  assign report_out.lock_number     = out_lock_number;
  assign report_out.new_level       = out_new_level;
  assign report_out.debounced_state = out_debounced_state;

endmodule

FILE: rtl/core/sbdcr_diff_scan.sv
module sbdcr_diff_scan #(
  parameter int W = 32
) (
  input  logic [W-1:0]     diff,
  output sbdcr_pkg::scan_t scan
);

  always_comb begin
    scan.found = |diff;
    scan.index = '0;
    scan.count = '0;
    // lowest set bit wins
    for (int i = W - 1; i >= 0; i--) begin
      if (diff[i]) begin
        scan.index = sbdcr_pkg::LOCK_NUM_W'(i);
      end
    end
    for (int i = 0; i < W; i++) begin
      scan.count = scan.count + sbdcr_pkg::LOCK_NUM_W'(diff[i]);
    end
  end

endmodule

FILE: rtl/core/sbdcr_checker.sv
`include "switch_bank_debounce_change_reporter_macros.svh"

module sbdcr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sbdcr_pkg::LOCK_NUM_W-1:0] lock_number,
  input logic                             new_level,
  input logic [sbdcr_pkg::SENSE_W-1:0]    debounced_state
);

  // held report keeps its payload
  `SBDCR_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(lock_number) && $stable(new_level) && $stable(debounced_state), "report changed while stalled")

  // a fresh report comes from a tick taken earlier through the input register
  `SBDCR_ASSERT_RST(a_out_from_tick, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "report without a tick")

  // reset drops any held report
  `SBDCR_ASSERT(a_reset_clears, clk, $past(rst) |-> !out_valid, "report present after reset")

  // input side is open right after reset
  `SBDCR_ASSERT(a_ready_after_reset, clk, $past(rst) && !rst |-> in_ready, "not ready after reset")

endmodule

bind switch_bank_debounce_change_reporter sbdcr_checker u_sbdcr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (lock_in.valid),
  .in_ready        (lock_in.ready),
  .out_valid       (report_out.valid),
  .out_ready       (report_out.ready),
  .lock_number     (report_out.lock_number),
  .new_level       (report_out.new_level),
  .debounced_state (report_out.debounced_state)
);

FILE: dv/switch_bank_debounce_change_reporter_test.sv
`timescale 1ns / 100ps

module switch_bank_debounce_change_reporter_test;

  localparam int SENSE_W = sbdcr_pkg::SENSE_W;
  localparam int LOCK_NUM_W = sbdcr_pkg::LOCK_NUM_W;
  localparam int CFG_IDX_W = sbdcr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sbdcr_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_SHOWN = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [LOCK_NUM_W-1:0] lock_number;
    logic                  new_level;
    logic [SENSE_W-1:0]    debounced_state;
  } lock_report_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_REPORT
  } row_check_t;

  typedef struct packed {
    logic [SENSE_W-1:0] word;
    row_check_t         check;
    lock_report_t       report;
  } script_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] detect;
    logic [CFG_DATA_W-1:0] report;
    logic [15:0]           ticks;
  } setting_t;

  logic clk;
  logic rst;

  sbdcr_in_if  lock_if ();
  sbdcr_out_if rep_if ();
  sbdcr_cfg_if cfg_if ();

  switch_bank_debounce_change_reporter #(
    .NUM_LOCKS(SENSE_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .lock_in   (lock_if),
    .report_out(rep_if),
    .cfg       (cfg_if)
  );

  // predictor state
  logic [CFG_DATA_W-1:0] det_ivl;
  logic [CFG_DATA_W-1:0] rpt_ivl;
  sbdcr_pkg::phase_t     det_phase;
  logic [SENSE_W-1:0]    sample_a;
  logic [SENSE_W-1:0]    sample_b;
  logic [15:0]           det_timer;
  logic [SENSE_W-1:0]    settled_word;
  logic [15:0]           rpt_timer;
  logic [SENSE_W-1:0]    announced_word;
  logic [SENSE_W-1:0]    snapshot_word;
  logic [LOCK_NUM_W-1:0] changes_left;

  lock_report_t pending_reports[$];
  script_row_t  script[$];
  setting_t     settings[$];

  int fault_count;
  int ticks_sent;
  int reports_checked;
  int cycle_count;
  bit calm;

  function automatic script_row_t row(input logic [SENSE_W-1:0] word, input row_check_t check,
                                      input logic [LOCK_NUM_W-1:0] lock_number,
                                      input logic level, input logic [SENSE_W-1:0] state);
    script_row_t r;
    r.word = word;
    r.check = check;
    r.report.lock_number = lock_number;
    r.report.new_level = level;
    r.report.debounced_state = state;
    return r;
  endfunction

  function automatic setting_t setting(input logic [CFG_DATA_W-1:0] detect,
                                       input logic [CFG_DATA_W-1:0] report,
                                       input logic [15:0] ticks);
    setting_t s;
    s.detect = detect;
    s.report = report;
    s.ticks = ticks;
    return s;
  endfunction

  function automatic void model_reset();
    det_ivl = sbdcr_pkg::DETECT_INTERVAL_RESET;
    rpt_ivl = sbdcr_pkg::REPORT_INTERVAL_RESET;
    det_phase = sbdcr_pkg::PH_READY;
    sample_a = '0;
    sample_b = '0;
    det_timer = '0;
    settled_word = '0;
    rpt_timer = '0;
    announced_word = '0;
    snapshot_word = '0;
    changes_left = '0;
  endfunction

  // one timer tick: debounce step, then the paced change reporter
  function automatic bit debounce_and_report(input logic [SENSE_W-1:0] sense,
                                             output lock_report_t rep);
    logic [SENSE_W-1:0] diff;
    bit hit;
    hit = 1'b0;
    rep = '0;
    if (det_timer != 0) det_timer = det_timer - 1'b1;
    if (rpt_timer != 0) rpt_timer = rpt_timer - 1'b1;
    case (det_phase)
      sbdcr_pkg::PH_READY: begin
        det_timer = det_ivl;
        det_phase = sbdcr_pkg::PH_FIRST;
      end
      sbdcr_pkg::PH_FIRST: begin
        if (det_timer == 0) begin
          sample_a = sense;
          det_timer = det_ivl;
          det_phase = sbdcr_pkg::PH_SECOND;
        end
      end
      sbdcr_pkg::PH_SECOND: begin
        if (det_timer == 0) begin
          sample_b = sense;
          det_phase = sbdcr_pkg::PH_COMMIT;
        end
      end
      default: begin
        if (sample_a == sample_b) settled_word = sample_a;
        det_phase = sbdcr_pkg::PH_READY;
      end
    endcase
    if (rpt_timer == 0) begin
      if (changes_left == 0) begin
        announced_word = snapshot_word;
        snapshot_word = settled_word;
        changes_left = LOCK_NUM_W'($countones(announced_word ^ snapshot_word));
      end
      if (changes_left != 0) begin
        diff = announced_word ^ snapshot_word;
        for (int i = 0; i < SENSE_W; i++) begin
          if (!hit && diff[i]) begin
            rep.lock_number = sbdcr_pkg::LOCK_NUM_BASE + LOCK_NUM_W'(i);
            rep.new_level = snapshot_word[i];
            rep.debounced_state = settled_word;
            announced_word[i] = ~announced_word[i];
            hit = 1'b1;
          end
        end
        changes_left = changes_left - 1'b1;
      end
      rpt_timer = rpt_ivl;
    end
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_SHOWN) $display("%0t: %s", $time, msg);
  endtask

  // register writes keep the request up across back to back writes
  task automatic write_settings(input logic [CFG_DATA_W-1:0] detect,
                                input logic [CFG_DATA_W-1:0] report, input bit poke_unused);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sbdcr_pkg::REG_DETECT_INTERVAL;
    cfg_if.data <= detect;
    do @(posedge clk); while (!cfg_if.ready);
    det_ivl = detect;
    cfg_if.index <= sbdcr_pkg::REG_REPORT_INTERVAL;
    cfg_if.data <= report;
    do @(posedge clk); while (!cfg_if.ready);
    rpt_ivl = report;
    if (poke_unused) begin
      cfg_if.index <= REG_UNUSED;
      cfg_if.data <= CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_tick(input logic [SENSE_W-1:0] word, input row_check_t check,
                           input lock_report_t typed);
    lock_report_t rep;
    bit hit;
    int gap;
    lock_if.valid <= 1'b1;
    lock_if.lock_inputs <= word;
    do @(posedge clk); while (!lock_if.ready);
    hit = debounce_and_report(word, rep);
    ticks_sent++;
    case (check)
      CHK_MODEL: if (hit) pending_reports.push_back(rep);
      CHK_REPORT: pending_reports.push_back(typed);
      default: ;
    endcase
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      lock_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_reports();
    int waited;
    waited = 0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      note_fault($sformatf("%0d expected reports never arrived", pending_reports.size()));
      pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : check_reports
    lock_report_t want;
    if (!rst && rep_if.valid && rep_if.ready) begin
      if (pending_reports.size() == 0) begin
        note_fault($sformatf("unexpected report: lock %0d level %0d state %h",
                             rep_if.lock_number, rep_if.new_level, rep_if.debounced_state));
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (rep_if.lock_number !== want.lock_number || rep_if.new_level !== want.new_level ||
            rep_if.debounced_state !== want.debounced_state) begin
          note_fault($sformatf("report mismatch: exp lock %0d level %0d state %h, got %0d %0d %h",
                               want.lock_number, want.new_level, want.debounced_state,
                               rep_if.lock_number, rep_if.new_level, rep_if.debounced_state));
        end
      end
    end
  end

  // receiver side stalls
  initial begin : report_sink
    int run;
    int gap;
    rep_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      rep_if.ready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        rep_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [SENSE_W-1:0] held;
    logic [SENSE_W-1:0] word;
    setting_t s;
    int run_left;
    int run_max;
    int pause_at;

    model_reset();
    fault_count = 0;
    ticks_sent = 0;
    reports_checked = 0;
    calm = 1'b0;

    rst <= 1'b1;
    lock_if.valid <= 1'b0;
    lock_if.lock_inputs <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero intervals: one debounce phase and one reporter run per tick
    script.push_back(row(32'h8000_0001, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h8000_0001, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h8000_0001, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_REPORT, 6'd1, 1'b1, 32'h8000_0001));
    script.push_back(row(32'h0000_0000, CHK_REPORT, 6'd32, 1'b1, 32'h8000_0001));
    // reporter snapshot with nothing changed
    script.push_back(row(32'h0000_0000, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    // samples differ, word kept
    script.push_back(row(32'h1234_5678, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_REPORT, 6'd1, 1'b0, 32'h0));
    script.push_back(row(32'hFFFF_FFFF, CHK_REPORT, 6'd32, 1'b0, 32'h0));
    script.push_back(row(32'hFFFF_FFFF, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'hFFFF_FFFF, CHK_QUIET, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_0000, CHK_REPORT, 6'd1, 1'b1, 32'hFFFF_FFFF));
    script.push_back(row(32'hFFFF_0000, CHK_MODEL, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h0000_FFFF, CHK_MODEL, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'h5555_5555, CHK_MODEL, 6'd0, 1'b0, 32'h0));
    script.push_back(row(32'hAAAA_AAAA, CHK_MODEL, 6'd0, 1'b0, 32'h0));

    settings.push_back(setting(16'd0, 16'd0, 16'd380));
    settings.push_back(setting(16'd1, 16'd0, 16'd200));
    settings.push_back(setting(16'd2, 16'd1, 16'd250));
    settings.push_back(setting(16'd0, 16'd3, 16'd250));
    settings.push_back(setting(16'd5, 16'd2, 16'd250));
    settings.push_back(setting(16'd3, 16'd7, 16'd200));
    settings.push_back(setting(16'd1, 16'd1, 16'd200));
    // longest intervals last, their reloaded timers outlast the run
    settings.push_back(setting(16'hFFFF, 16'hFFFF, 16'd100));

    write_settings(16'd0, 16'd0, 1'b0);
    foreach (script[k]) send_tick(script[k].word, script[k].check, script[k].report);
    lock_if.valid <= 1'b0;
    drain_reports();

    foreach (settings[p]) begin
      s = settings[p];
      write_settings(s.detect, s.report, p == 0);
      calm = (p % 3 == 2);
      held = $urandom;
      run_left = 0;
      run_max = (s.detect > 8) ? 20 : 2 * s.detect + 4;
      pause_at = (p == 1) ? s.ticks / 2 : -1;
      for (int n = 0; n < s.ticks; n++) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: held = held ^ (32'h1 << $urandom_range(0, 31));
            4, 5: held = held ^ (32'h1 << $urandom_range(0, 31)) ^ (32'h1 << $urandom_range(0, 31));
            6, 7: held = $urandom;
            8: held = '0;
            default: held = '1;
          endcase
          run_left = $urandom_range(1, run_max);
        end
        word = held;
        // one-tick glitch on the held word
        if ($urandom_range(0, 99) < 8) word = held ^ $urandom;
        run_left--;
        send_tick(word, CHK_MODEL, '0);
        if (n == pause_at || $urandom_range(0, 199) == 0) begin
          lock_if.valid <= 1'b0;
          drain_reports();
        end
      end
      lock_if.valid <= 1'b0;
      drain_reports();
    end

    $display("sent %0d lock ticks over %0d interval settings, %0d change reports checked",
             ticks_sent, settings.size() + 1, reports_checked);
    $display("%0d mismatches counted", fault_count);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
